>>> design/pbc_pkg.sv
// Shared widths, constants and the queued job type for the point-biserial correlation core.
package pbc_pkg;

	localparam int SAMPLE_W          = 24;
	localparam int SUM_W             = 40;
	localparam int CNT_W             = 25;
	localparam int SQ_W              = 64;
	localparam int CORR_W            = 17;
	localparam int Y_W               = 16;
	localparam int K_W               = 4;
	localparam int DIFF_W            = 66;
	localparam int NN_W              = 2 * CNT_W + 2;
	localparam int PROD_W            = 200;
	localparam int QUEUE_DEPTH       = 2;
	localparam int DEF_MAX_SAMPLES   = 65536;
	localparam int DEF_FRACTION_BITS = 16;

	localparam logic [CORR_W-1:0] CORR_ONE  = CORR_W'(1) << Y_W;
	localparam logic [CORR_W-1:0] CORR_ZERO = '0;

	typedef struct packed {
		logic [SUM_W-1:0] zero_sum;
		logic [SUM_W-1:0] one_sum;
		logic [CNT_W-1:0] zero_count;
		logic [CNT_W-1:0] one_count;
		logic [SQ_W-1:0]  sq_sum;
	} job_t;

endpackage

>>> design/pbc_front.sv
// Front end: sample intake, per-class accumulation and column hand-off.
module pbc_front #(
	parameter int MAX_SAMPLES   = pbc_pkg::DEF_MAX_SAMPLES,
	parameter int FRACTION_BITS = pbc_pkg::DEF_FRACTION_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic signed [pbc_pkg::SAMPLE_W-1:0] sample_value,
	input  logic                                class_label,
	input  logic signed [pbc_pkg::SAMPLE_W-1:0] column_mean,
	input  logic                                last_sample,
	input  logic                                sample_valid,
	output logic                                sample_ready,
	output logic                                push,
	output pbc_pkg::job_t                       push_job,
	input  logic                                q_full
);
	import pbc_pkg::*;

	logic                       valid_s1;
	logic signed [SAMPLE_W-1:0] x_s1;
	logic                       label_s1;
	logic                       last_s1;
	logic [SAMPLE_W:0]          ad_s1;

	logic [SUM_W-1:0] zero_sum_q, one_sum_q;
	logic [CNT_W-1:0] zero_count_q, one_count_q;
	logic [SQ_W-1:0]  sq_sum_q;

	logic signed [SAMPLE_W:0] diff;
	logic [SAMPLE_W:0]        ad;
	logic [2*SAMPLE_W+1:0]    sq;
	logic [CNT_W:0]           n_sum;
	logic                     take;
	logic                     advance;
	logic [SUM_W-1:0]         x_ext;
	job_t                     nxt;

	assign diff = {sample_value[SAMPLE_W-1], sample_value}
		- {column_mean[SAMPLE_W-1], column_mean};
	assign ad   = diff[SAMPLE_W] ? (~diff + 1'b1) : diff;

	assign advance      = valid_s1 && (!last_s1 || !q_full);
	assign sample_ready = !valid_s1 || advance;
	assign push         = advance && last_s1;

	assign sq    = ad_s1 * ad_s1;
	assign n_sum = {1'b0, zero_count_q} + {1'b0, one_count_q};
	assign take  = n_sum < (CNT_W+1)'(MAX_SAMPLES);
	assign x_ext = SUM_W'(x_s1);

	always_comb begin
		nxt.zero_sum   = zero_sum_q;
		nxt.one_sum    = one_sum_q;
		nxt.zero_count = zero_count_q;
		nxt.one_count  = one_count_q;
		nxt.sq_sum     = sq_sum_q;
		if (take) begin
			if (label_s1) begin
				nxt.one_sum   = one_sum_q + x_ext;
				nxt.one_count = one_count_q + 1'b1;
			end else begin
				nxt.zero_sum   = zero_sum_q + x_ext;
				nxt.zero_count = zero_count_q + 1'b1;
			end
			nxt.sq_sum = sq_sum_q + SQ_W'(sq >> FRACTION_BITS);
		end
	end

	assign push_job = nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid) begin
			x_s1     <= sample_value;
			label_s1 <= class_label;
			last_s1  <= last_sample;
			ad_s1    <= ad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_sum_q   <= '0;
			one_sum_q    <= '0;
			zero_count_q <= '0;
			one_count_q  <= '0;
			sq_sum_q     <= '0;
		end else if (advance) begin
			if (last_s1) begin
				zero_sum_q   <= '0;
				one_sum_q    <= '0;
				zero_count_q <= '0;
				one_count_q  <= '0;
				sq_sum_q     <= '0;
			end else begin
				zero_sum_q   <= nxt.zero_sum;
				one_sum_q    <= nxt.one_sum;
				zero_count_q <= nxt.zero_count;
				one_count_q  <= nxt.one_count;
				sq_sum_q     <= nxt.sq_sum;
			end
		end
	end

endmodule

>>> design/pbc_queue.sv
// Short queue of finished column totals between front and back end.
module pbc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pbc_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output pbc_pkg::job_t pop_job,
	output logic          avail
);
	import pbc_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

	job_t              mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wptr_q, rptr_q;
	logic [CNT_QW-1:0] count_q;

	assign full    = count_q == CNT_QW'(QUEUE_DEPTH);
	assign avail   = count_q != '0;
	assign pop_job = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> avail)
		else $error("pop from empty queue");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count lost a push");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_QW'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

endmodule

>>> design/pbc_back.sv
// Back end: serial multiplier, bitwise root search and result register.
module pbc_back #(
	parameter int FRACTION_BITS = pbc_pkg::DEF_FRACTION_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              avail,
	input  pbc_pkg::job_t                     pop_job,
	output logic                              pop,
	output logic [pbc_pkg::CORR_W-1:0]        correlation,
	output logic                              degenerate,
	output logic                              result_valid,
	input  logic                              result_ready
);
	import pbc_pkg::*;

	localparam int NUM_SH = 32 - FRACTION_BITS;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CHECK, ST_MA, ST_MB, ST_MDD, ST_MNUM, ST_MNN, ST_MP,
		ST_MNNP, ST_MDEN, ST_SAT, ST_TA, ST_TB, ST_OUT
	} state_t;

	state_t            state_q;
	job_t              job_q;
	logic [PROD_W-1:0] acc_q, mcand_q, num_q, den_q, p_q, yd_q, t_q;
	logic [DIFF_W-1:0] mplier_q, a_q;
	logic [NN_W-1:0]   nn_q;
	logic [Y_W-1:0]    y_q;
	logic [K_W-1:0]    k_q;
	logic [CORR_W-1:0] res_q;
	logic              degen_q;

	logic [SUM_W-1:0]  mag0, mag1;
	logic [CNT_W:0]    n_sum, nm1;
	logic              mul_done;
	logic [PROD_W-1:0] acc_nxt, t_nxt;
	logic [DIFF_W-1:0] b_val, d_val;
	logic              fits;
	logic [Y_W-1:0]    y_nxt;

	assign mag0     = job_q.zero_sum[SUM_W-1] ? (~job_q.zero_sum + 1'b1) : job_q.zero_sum;
	assign mag1     = job_q.one_sum[SUM_W-1] ? (~job_q.one_sum + 1'b1) : job_q.one_sum;
	assign n_sum    = {1'b0, job_q.zero_count} + {1'b0, job_q.one_count};
	assign nm1      = n_sum - 1'b1;
	assign mul_done = mplier_q == '0;
	assign acc_nxt  = acc_q + (mplier_q[0] ? mcand_q : '0);
	assign b_val    = acc_q[DIFF_W-1:0];
	assign t_nxt    = t_q + (den_q << {k_q, 1'b0});
	assign fits     = t_nxt <= num_q;
	assign y_nxt    = fits ? (y_q | (Y_W'(1) << k_q)) : y_q;
	assign pop      = (state_q == ST_IDLE) && avail;

	always_comb begin
		if (job_q.zero_sum[SUM_W-1] != job_q.one_sum[SUM_W-1]) begin
			d_val = a_q + b_val;
		end else if (a_q >= b_val) begin
			d_val = a_q - b_val;
		end else begin
			d_val = b_val - a_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			result_valid <= 1'b0;
		end else begin
			if (result_valid && result_ready && state_q != ST_OUT) begin
				result_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (avail) begin
						job_q   <= pop_job;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					acc_q <= '0;
					if (n_sum < (CNT_W+1)'(2) || job_q.sq_sum == '0) begin
						res_q   <= CORR_ZERO;
						degen_q <= 1'b1;
						state_q <= ST_OUT;
					end else if (job_q.zero_count == '0 || job_q.one_count == '0) begin
						res_q   <= CORR_ZERO;
						degen_q <= 1'b0;
						state_q <= ST_OUT;
					end else begin
						degen_q  <= 1'b0;
						mcand_q  <= PROD_W'(mag0);
						mplier_q <= DIFF_W'(job_q.one_count);
						state_q  <= ST_MA;
					end
				end
				ST_MA, ST_MB, ST_MDD, ST_MNUM, ST_MNN, ST_MP, ST_MNNP, ST_MDEN: begin
					if (!mul_done) begin
						acc_q    <= acc_nxt;
						mcand_q  <= mcand_q << 1;
						mplier_q <= mplier_q >> 1;
					end else begin
						acc_q <= '0;
						case (state_q)
							ST_MA: begin
								a_q      <= acc_q[DIFF_W-1:0];
								mcand_q  <= PROD_W'(mag1);
								mplier_q <= DIFF_W'(job_q.zero_count);
								state_q  <= ST_MB;
							end
							ST_MB: begin
								mcand_q  <= PROD_W'(d_val);
								mplier_q <= d_val;
								state_q  <= ST_MDD;
							end
							ST_MDD: begin
								mcand_q  <= acc_q;
								mplier_q <= DIFF_W'(nm1);
								state_q  <= ST_MNUM;
							end
							ST_MNUM: begin
								num_q    <= acc_q << NUM_SH;
								mcand_q  <= PROD_W'(n_sum);
								mplier_q <= DIFF_W'(n_sum);
								state_q  <= ST_MNN;
							end
							ST_MNN: begin
								nn_q     <= acc_q[NN_W-1:0];
								mcand_q  <= PROD_W'(job_q.zero_count);
								mplier_q <= DIFF_W'(job_q.one_count);
								state_q  <= ST_MP;
							end
							ST_MP: begin
								mcand_q  <= PROD_W'(nn_q);
								mplier_q <= acc_q[DIFF_W-1:0];
								state_q  <= ST_MNNP;
							end
							ST_MNNP: begin
								mcand_q  <= acc_q;
								mplier_q <= DIFF_W'(job_q.sq_sum);
								state_q  <= ST_MDEN;
							end
							default: begin
								den_q   <= acc_q;
								state_q <= ST_SAT;
							end
						endcase
					end
				end
				ST_SAT: begin
					if ((den_q << 32) <= num_q) begin
						res_q   <= CORR_ONE;
						state_q <= ST_OUT;
					end else begin
						p_q     <= '0;
						yd_q    <= '0;
						y_q     <= '0;
						k_q     <= K_W'(Y_W - 1);
						state_q <= ST_TA;
					end
				end
				ST_TA: begin
					t_q     <= p_q + (yd_q << ({1'b0, k_q} + 5'd1));
					state_q <= ST_TB;
				end
				ST_TB: begin
					if (fits) begin
						p_q  <= t_nxt;
						yd_q <= yd_q + (den_q << k_q);
					end
					y_q <= y_nxt;
					if (k_q == '0) begin
						res_q   <= {1'b0, y_nxt};
						state_q <= ST_OUT;
					end else begin
						k_q     <= k_q - 1'b1;
						state_q <= ST_TA;
					end
				end
				ST_OUT: begin
					if (!result_valid || result_ready) begin
						result_valid <= 1'b1;
						correlation  <= res_q;
						degenerate   <= degen_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q == ST_CHECK)
		else $error("popped job not taken up");
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> res_q <= CORR_ONE)
		else $error("result beyond one");
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && degenerate) |-> correlation == CORR_ZERO)
		else $error("degenerate result not zero");

endmodule

>>> design/point_biserial_correlation_core.sv
// Top level of the point-biserial correlation core.
// Usage:
//   Stream one feature column as sample transactions (sample_valid/sample_ready):
//   value, class label bit, column mean and a last-sample mark. The front end
//   takes one transaction per cycle, unless a last sample waits on a full queue,
//   and accumulates class sums, class counts and the sum of squared deviations.
//   On the last sample the column totals are handed to a two-entry queue and
//   the accumulators clear for the next column. The back end forms the
//   coefficient with one shared shift-add multiplier for all eight products (one
//   multiplier bit per cycle) and a bitwise root search (one result bit per
//   ST_TA/ST_TB pair). The back end gives one result per pass and takes the
//   next column's totals from the queue only when idle.
//   The result transaction (result_valid/result_ready) carries correlation in
//   unsigned Q1.16, saturated at 1.0, and degenerate. A stalled receiver holds
//   the result register; the back end then waits, the queue fills, and the
//   front end stops taking a last sample only when the queue is full.
//   Reset clears accumulators, queue and result valid; no sweep is needed.
module point_biserial_correlation_core #(
	parameter int MAX_SAMPLES   = pbc_pkg::DEF_MAX_SAMPLES,
	parameter int FRACTION_BITS = pbc_pkg::DEF_FRACTION_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic signed [pbc_pkg::SAMPLE_W-1:0] sample_value,
	input  logic                                class_label,
	input  logic signed [pbc_pkg::SAMPLE_W-1:0] column_mean,
	input  logic                                last_sample,
	input  logic                                sample_valid,
	output logic                                sample_ready,
	output logic [pbc_pkg::CORR_W-1:0]          correlation,
	output logic                                degenerate,
	output logic                                result_valid,
	input  logic                                result_ready
);
	import pbc_pkg::*;

	logic push, q_full, pop, avail;
	job_t push_job, pop_job;

	pbc_front #(
		.MAX_SAMPLES  (MAX_SAMPLES),
		.FRACTION_BITS(FRACTION_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_value(sample_value),
		.class_label (class_label),
		.column_mean (column_mean),
		.last_sample (last_sample),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.push        (push),
		.push_job    (push_job),
		.q_full      (q_full)
	);

	pbc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.full    (q_full),
		.pop     (pop),
		.pop_job (pop_job),
		.avail   (avail)
	);

	pbc_back #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.avail       (avail),
		.pop_job     (pop_job),
		.pop         (pop),
		.correlation (correlation),
		.degenerate  (degenerate),
		.result_valid(result_valid),
		.result_ready(result_ready)
	);

endmodule

>>> dv/point_biserial_correlation_checker.sv
// Watches both channels of the correlation core, predicts each column result and compares.
`timescale 1ns / 1ps

module point_biserial_correlation_checker #(
	parameter int MAX_SAMPLES   = pbc_pkg::DEF_MAX_SAMPLES,
	parameter int FRACTION_BITS = pbc_pkg::DEF_FRACTION_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic signed [pbc_pkg::SAMPLE_W-1:0] sample_value,
	input  logic                                class_label,
	input  logic signed [pbc_pkg::SAMPLE_W-1:0] column_mean,
	input  logic                                last_sample,
	input  logic                                sample_valid,
	input  logic                                sample_ready,
	input  logic [pbc_pkg::CORR_W-1:0]          correlation,
	input  logic                                degenerate,
	input  logic                                result_valid,
	input  logic                                result_ready,
	output int                                  errors,
	output int                                  outstanding
);

	typedef struct {
		logic [pbc_pkg::CORR_W-1:0] corr;
		logic                       degen;
	} coeff_t;

	coeff_t                              coeff_q[$];
	logic signed [pbc_pkg::SUM_W-1:0]    zero_sum, one_sum;
	logic [pbc_pkg::CNT_W-1:0]           zero_cnt, one_cnt;
	logic [pbc_pkg::SQ_W-1:0]            sq_sum;

	function automatic coeff_t column_coeff();
		coeff_t             c;
		logic [255:0]       n0, n1, n, q, num, den, lhs, mid;
		logic signed [255:0] a, b, d;
		int unsigned        lo, hi, m;
		n0 = zero_cnt;
		n1 = one_cnt;
		n = n0 + n1;
		q = sq_sum;
		c.corr = '0;
		c.degen = 1'b0;
		if (n < 2 || q == 0) begin
			c.degen = 1'b1;
			return c;
		end
		if (n0 == 0 || n1 == 0)
			return c;
		a = zero_sum;
		b = one_sum;
		d = a * $signed(n1) - b * $signed(n0);
		if (d < 0)
			d = -d;
		num = (d * d * (n - 1)) << (32 - FRACTION_BITS);
		den = n * n * n0 * n1 * q;
		lo = 0;
		hi = 65537;
		while (hi - lo > 1) begin
			m = lo + (hi - lo) / 2;
			mid = m;
			lhs = mid * mid * den;
			if (lhs <= num)
				lo = m;
			else
				hi = m;
		end
		c.corr = pbc_pkg::CORR_W'(lo);
		return c;
	endfunction

	task automatic take_sample();
		longint      diff;
		logic [63:0] ad;
		if (longint'(zero_cnt) + longint'(one_cnt) < MAX_SAMPLES) begin
			diff = longint'(sample_value) - longint'(column_mean);
			ad = diff < 0 ? -diff : diff;
			if (class_label) begin
				one_sum = one_sum + pbc_pkg::SUM_W'(sample_value);
				one_cnt = one_cnt + 1'b1;
			end else begin
				zero_sum = zero_sum + pbc_pkg::SUM_W'(sample_value);
				zero_cnt = zero_cnt + 1'b1;
			end
			sq_sum = sq_sum + ((ad * ad) >> FRACTION_BITS);
		end
		if (last_sample) begin
			coeff_q.push_back(column_coeff());
			zero_sum = '0;
			one_sum = '0;
			zero_cnt = '0;
			one_cnt = '0;
			sq_sum = '0;
		end
	endtask

	initial begin
		errors = 0;
		zero_sum = '0;
		one_sum = '0;
		zero_cnt = '0;
		one_cnt = '0;
		sq_sum = '0;
	end

	assign outstanding = coeff_q.size();

	always @(posedge clk) begin
		coeff_t e;
		if (arst_n) begin
			if (sample_valid && sample_ready)
				take_sample();
			if (result_valid && result_ready) begin
				if (coeff_q.size() == 0) begin
					$error("unexpected result transaction: correlation %0d degenerate %0d",
						correlation, degenerate);
					errors++;
				end else begin
					e = coeff_q.pop_front();
					if (correlation !== e.corr) begin
						$error("correlation: expected %0d, actual %0d", e.corr, correlation);
						errors++;
					end
					if (degenerate !== e.degen) begin
						$error("degenerate: expected %0d, actual %0d", e.degen, degenerate);
						errors++;
					end
				end
			end
		end
	end

endmodule

>>> dv/point_biserial_correlation_core_tb.sv
// Testbench top: clock, reset, sample stimulus, result back-pressure and the verdict.
`timescale 1ns / 1ps

module point_biserial_correlation_core_tb;

	localparam int QUIET_LIMIT = 20000;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic signed [pbc_pkg::SAMPLE_W-1:0] sample_value = '0;
	logic                          class_label = 1'b0;
	logic signed [pbc_pkg::SAMPLE_W-1:0] column_mean = '0;
	logic                          last_sample = 1'b0;
	logic                          sample_valid = 1'b0;
	logic                          sample_ready;
	logic [pbc_pkg::CORR_W-1:0]    correlation;
	logic                          degenerate;
	logic                          result_valid;
	logic                          result_ready = 1'b0;
	int                            errors, outstanding;
	int unsigned                   send_idle_pct = 0, recv_idle_pct = 0;
	int unsigned                   hold_request = 0, quiet = 0;

	always #1 clk = ~clk;

	point_biserial_correlation_core dut (.*);

	point_biserial_correlation_checker chk (.*);

	always @(posedge clk) begin
		int unsigned hold_left;
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			result_ready <= 1'b0;
			hold_left--;
		end else begin
			result_ready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((sample_valid && sample_ready) || (result_valid && result_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("point_biserial_correlation_core_tb: errors");
			$finish;
		end
	end

	task automatic send_sample(logic signed [23:0] v, logic l, logic signed [23:0] m,
			logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_value <= v;
		class_label <= l;
		column_mean <= m;
		last_sample <= last;
		sample_valid <= 1'b1;
		@(posedge clk);
		while (!sample_ready)
			@(posedge clk);
	endtask

	function automatic logic signed [23:0] draw_value(logic signed [23:0] m, int unsigned mode);
		case (mode)
			0: return 24'($urandom);
			1: return m + 24'($signed($urandom_range(0, 512)) - 256);
			default: return m + 24'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
		endcase
	endfunction

	task automatic send_column(int unsigned len);
		logic signed [23:0] m;
		int unsigned        mode, lab_mode;
		m = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
		mode = $urandom_range(2);
		lab_mode = $urandom_range(5);
		for (int unsigned i = 0; i < len; i++)
			send_sample(draw_value(m, mode),
				lab_mode == 0 ? 1'b0 : lab_mode == 1 ? 1'b1 : 1'($urandom),
				m, i == len - 1);
	endtask

	task automatic random_phase(int unsigned items);
		int unsigned sent, len;
		sent = 0;
		while (sent < items) begin
			len = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
			send_column(len);
			sent += len;
		end
		sample_valid <= 1'b0;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_sample(-24'sd8388608, 1'b0, 24'sd8388607, 1'b1);
		send_sample(24'sd1234, 1'b0, 24'sd1234, 1'b0);
		send_sample(24'sd1234, 1'b1, 24'sd1234, 1'b1);
		send_sample(24'sd70000, 1'b0, 24'sd0, 1'b0);
		send_sample(-24'sd90000, 1'b0, 24'sd0, 1'b0);
		send_sample(24'sd5, 1'b0, 24'sd0, 1'b1);
		send_sample(24'sd0, 1'b0, 24'sd500, 1'b0);
		send_sample(24'sd1000, 1'b1, 24'sd500, 1'b1);
		send_sample(24'sd8388607, 1'b1, 24'sd0, 1'b0);
		send_sample(-24'sd8388608, 1'b0, 24'sd0, 1'b0);
		send_sample(-24'sd8388608, 1'b0, 24'sd8388607, 1'b0);
		send_sample(24'sd8388607, 1'b1, -24'sd8388608, 1'b1);
		send_sample(24'sd100000, 1'b0, 24'sd30000, 1'b0);
		send_sample(-24'sd20000, 1'b1, 24'sd30000, 1'b0);
		send_sample(24'sd45000, 1'b0, 24'sd30000, 1'b0);
		send_sample(24'sd3000, 1'b1, 24'sd30000, 1'b0);
		send_sample(24'sd61000, 1'b1, 24'sd30000, 1'b1);
		sample_valid <= 1'b0;

		random_phase(400);
		send_idle_pct = 76;
		random_phase(400);
		send_idle_pct = 0;
		recv_idle_pct = 76;
		random_phase(400);
		send_idle_pct = 17;
		recv_idle_pct = 17;
		random_phase(400);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_request = 3000;
		for (int i = 0; i < 20; i++)
			send_column(1);
		sample_valid <= 1'b0;

		random_phase(100);

		while (outstanding != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
		if (errors == 0)
			$display("point_biserial_correlation_core_tb: clean");
		else
			$display("point_biserial_correlation_core_tb: errors");
		$finish;
	end

endmodule
